// ===== rtl/sem_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sem_pkg
// Types, constants and helpers shared by the Sobel edge magnitude unit.
// ---------------------------------------------------------------------------
package sem_pkg;

	// default size limits of the frame
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// configuration register widths and reset values
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 1;
	localparam logic [CFG_WIDTH_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
	localparam logic [CFG_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 13'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} sem_cfg_idx_t;

	// item kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// datapath widths
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int LINE_W = 2 * PIX_W;
	localparam int GRAD_W = 11;
	localparam int SQ_W   = 2 * GRAD_W;
	localparam int SUM_W  = 21;
	localparam int BASE_W = 16;

	typedef struct packed {
		logic              kind;
		logic [CH_W-1:0]   pixel_red;
		logic [CH_W-1:0]   pixel_green;
		logic [CH_W-1:0]   pixel_blue;
	} sem_in_t;

	typedef struct packed {
		logic [CH_W-1:0]   edge_red;
		logic [CH_W-1:0]   edge_green;
		logic [CH_W-1:0]   edge_blue;
		logic              frame_end;
	} sem_out_t;

	// per item control from the counters to the window datapath
	typedef struct packed {
		logic emit;
		logic last;
		logic row_top;
		logic row_bot;
		logic col_left;
		logic col_right;
	} sem_ctl_t;

	// result tag running alongside the datapath
	typedef struct packed {
		logic valid;
		logic last;
	} sem_tag_t;

	// address bits for a store of n entries, at least one
	function automatic int addr_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sobel_edge_magnitude_rgb_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_unit
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order.
// ---------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled; the pipeline
// only halts as a whole when a result waits at the output. The result for
// pixel j of a frame comes out with input item j + W + 1 (W the frame
// width), so W + 1 flush items after the last pixel push the final row out;
// frame_end marks the last result, after which the next pixel starts a new
// frame. The two previous rows live in one line memory of MAX_WIDTH entries
// x 48 bits, read and written back once per item (a bypass covers a one
// pixel wide frame). It needs no clearing after reset. Neighbours outside
// the frame count as zero. The user is to write the frame size registers
// only while no item is in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_unit #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire sem_pkg::sem_in_t                in_item,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output sem_pkg::sem_out_t                    out_item,
	input  wire logic                            cfg_write,
	input  wire logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW        = sem_pkg::addr_bits(MAX_WIDTH);
	localparam int ROOT_LAT  = sem_pkg::CH_W;

	logic                        adv;
	logic [AW-1:0]               rd_addr;
	logic                        live_s1;
	logic [AW-1:0]               addr_s1;
	logic [sem_pkg::PIX_W-1:0]   pix_s1;
	sem_pkg::sem_ctl_t           ctl_s1;
	logic [sem_pkg::LINE_W-1:0]  line_s1;
	logic [sem_pkg::LINE_W-1:0]  line_wr;
	logic [sem_pkg::SUM_W-1:0]   sum_s4 [3];
	sem_pkg::sem_tag_t           tag_s4;
	sem_pkg::sem_tag_t           tag_s [ROOT_LAT];
	logic [sem_pkg::CH_W-1:0]    edge_val [3];

	// whole pipeline moves unless a result waits at the output
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// counters and stage 1
	sem_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_addr   (rd_addr),
		.live_s1   (live_s1),
		.addr_s1   (addr_s1),
		.pix_s1    (pix_s1),
		.ctl_s1    (ctl_s1)
	);

	// line store: upper takes middle, middle takes the incoming pixel
	assign line_wr = {line_s1[sem_pkg::PIX_W-1:0], pix_s1};

	sem_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_addr (rd_addr),
		.rd_data (line_s1),
		.wr_en   (adv && live_s1),
		.wr_addr (addr_s1),
		.wr_data (line_wr)
	);

	// window and gradients
	sem_win u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.live_s1 (live_s1),
		.ctl_s1  (ctl_s1),
		.pix_s1  (pix_s1),
		.line_s1 (line_s1),
		.sum_s4  (sum_s4),
		.tag_s4  (tag_s4)
	);

	// one root unit per colour channel
	for (genvar ch = 0; ch < 3; ch++) begin : g_root
		sem_root u_root (
			.clk  (clk),
			.adv  (adv),
			.sum  (sum_s4[ch]),
			.root (edge_val[ch])
		);
	end

	// tags alongside the root stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROOT_LAT; i++) begin
				tag_s[i] <= '0;
			end
		end else if (adv) begin
			tag_s[0] <= tag_s4;
			for (int i = 1; i < ROOT_LAT; i++) begin
				tag_s[i] <= tag_s[i-1];
			end
		end
	end

	// output item
	assign out_valid           = tag_s[ROOT_LAT-1].valid;
	assign out_item.edge_red   = edge_val[0];
	assign out_item.edge_green = edge_val[1];
	assign out_item.edge_blue  = edge_val[2];
	assign out_item.frame_end  = tag_s[ROOT_LAT-1].last;

endmodule
`default_nettype wire

// ===== rtl/sem_line_mem.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sem_line_mem
// Line store: upper and middle row of one column per entry, registered read,
// with a bypass for a read that meets the write-back of the same entry.
// ---------------------------------------------------------------------------
module sem_line_mem #(
	parameter int DEPTH = sem_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 rd_en,
	input  wire logic [sem_pkg::addr_bits(DEPTH)-1:0] rd_addr,
	output logic      [sem_pkg::LINE_W-1:0]           rd_data,
	input  wire logic                                 wr_en,
	input  wire logic [sem_pkg::addr_bits(DEPTH)-1:0] wr_addr,
	input  wire logic [sem_pkg::LINE_W-1:0]           wr_data
);

	logic [sem_pkg::LINE_W-1:0] mem [DEPTH];
	logic [sem_pkg::LINE_W-1:0] rd_q;
	logic [sem_pkg::LINE_W-1:0] byp_q;
	logic                       byp_sel_q;

	// storage, write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			byp_q <= wr_data;
		end
	end

	// read and write of the same entry at one edge: take the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_sel_q <= 1'b0;
		end else if (rd_en) begin
			byp_sel_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_sel_q ? byp_q : rd_q;

endmodule
`default_nettype wire

// ===== rtl/sem_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sem_ctrl
// Configuration registers, input and output position counters, and the
// first pipeline stage that issues the line store read.
// ---------------------------------------------------------------------------
module sem_ctrl #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     adv,
	input  wire logic                                     in_valid,
	input  wire sem_pkg::sem_in_t                         in_item,
	input  wire logic                                     cfg_write,
	input  wire logic [sem_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  wire logic [sem_pkg::CFG_DATA_W-1:0]           cfg_data,
	output logic      [sem_pkg::addr_bits(MAX_WIDTH)-1:0] rd_addr,
	output logic                                          live_s1,
	output logic      [sem_pkg::addr_bits(MAX_WIDTH)-1:0] addr_s1,
	output logic      [sem_pkg::PIX_W-1:0]                pix_s1,
	output sem_pkg::sem_ctl_t                             ctl_s1
);

	localparam int AW = sem_pkg::addr_bits(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = HW + 1;

	logic [sem_pkg::CFG_WIDTH_W-1:0]  cfg_width_q;
	logic [sem_pkg::CFG_HEIGHT_W-1:0] cfg_height_q;
	logic [WW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [WW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;

	logic [WW-1:0]           eff_w;
	logic [HW-1:0]           eff_h;
	logic                    in_frame;
	logic                    ignore;
	logic                    live;
	logic                    ready;
	logic                    in_col_end;
	logic                    out_col_end;
	logic                    out_row_end;
	logic                    frame_last;
	logic [sem_pkg::PIX_W-1:0] pix;
	sem_pkg::sem_ctl_t       ctl;

	// effective frame size: zero counts as one, clamp at the limit
	always_comb begin
		if (cfg_width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(cfg_height_q);
		end
	end

	// item decode and position compares
	always_comb begin
		in_frame    = in_row_q < RW'(eff_h);
		ignore      = (in_item.kind == sem_pkg::KIND_FLUSH) && in_frame;
		live        = in_valid && adv && !ignore;
		if ((in_item.kind == sem_pkg::KIND_PIXEL) && in_frame) begin
			pix = {in_item.pixel_red, in_item.pixel_green, in_item.pixel_blue};
		end else begin
			pix = '0;
		end
		ready       = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
		in_col_end  = ((WW+1)'(in_col_q) + (WW+1)'(1)) >= (WW+1)'(eff_w);
		out_col_end = ((WW+1)'(out_col_q) + (WW+1)'(1)) >= (WW+1)'(eff_w);
		out_row_end = ((RW+1)'(out_row_q) + (RW+1)'(1)) >= (RW+1)'(eff_h);
		frame_last  = out_row_end && out_col_end;

		ctl.emit      = ready;
		ctl.last      = frame_last;
		ctl.row_top   = out_row_q != '0;
		ctl.row_bot   = !out_row_end;
		ctl.col_left  = out_col_q != '0;
		ctl.col_right = !out_col_end;
	end

	assign rd_addr = in_col_q[AW-1:0];

	// configuration registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= sem_pkg::RST_FRAME_WIDTH;
			cfg_height_q <= sem_pkg::RST_FRAME_HEIGHT;
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
		end else begin
			if (cfg_write) begin
				unique case (sem_pkg::sem_cfg_idx_t'(cfg_index))
					sem_pkg::CFG_FRAME_WIDTH: begin
						cfg_width_q <= cfg_data[sem_pkg::CFG_WIDTH_W-1:0];
					end
					sem_pkg::CFG_FRAME_HEIGHT: begin
						cfg_height_q <= cfg_data[sem_pkg::CFG_HEIGHT_W-1:0];
					end
				endcase
			end
			if (live) begin
				if (ready && frame_last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					if (in_col_end) begin
						in_col_q <= '0;
						if (in_row_q != '1) begin
							in_row_q <= in_row_q + RW'(1);
						end
					end else begin
						in_col_q <= in_col_q + WW'(1);
					end
					if (ready) begin
						if (out_col_end) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + RW'(1);
						end else begin
							out_col_q <= out_col_q + WW'(1);
						end
					end
				end
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
		end else if (adv) begin
			live_s1 <= live;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1 <= in_col_q[AW-1:0];
			pix_s1  <= pix;
			ctl_s1  <= ctl;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sem_win.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sem_win
// 3x3 window, border masking, Sobel gradients per channel and the sum of
// their squares.
// ---------------------------------------------------------------------------
module sem_win (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        live_s1,
	input  wire sem_pkg::sem_ctl_t           ctl_s1,
	input  wire logic [sem_pkg::PIX_W-1:0]   pix_s1,
	input  wire logic [sem_pkg::LINE_W-1:0]  line_s1,
	output logic      [sem_pkg::SUM_W-1:0]   sum_s4 [3],
	output sem_pkg::sem_tag_t                tag_s4
);

	localparam int CW = sem_pkg::CH_W;
	localparam int GW = sem_pkg::GRAD_W;

	logic [sem_pkg::PIX_W-1:0]  win_q [3][3];
	sem_pkg::sem_ctl_t          ctl_s2;
	logic                       rok [3];
	logic                       cok [3];
	logic [CW-1:0]              px [3][3][3];
	logic signed [GW-1:0]       gx [3];
	logic signed [GW-1:0]       gy [3];
	logic signed [GW-1:0]       gx_s3 [3];
	logic signed [GW-1:0]       gy_s3 [3];
	sem_pkg::sem_tag_t          tag_s3;
	logic signed [sem_pkg::SQ_W-1:0] sq_x [3];
	logic signed [sem_pkg::SQ_W-1:0] sq_y [3];

	// window shift: column 2 takes upper, middle and incoming pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (adv && live_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= line_s1[sem_pkg::LINE_W-1:sem_pkg::PIX_W];
			win_q[1][2] <= line_s1[sem_pkg::PIX_W-1:0];
			win_q[2][2] <= pix_s1;
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= {live_s1 && ctl_s1.emit, ctl_s1.last, ctl_s1.row_top,
				ctl_s1.row_bot, ctl_s1.col_left, ctl_s1.col_right};
		end
	end

	// border masking and gradients
	always_comb begin
		rok[0] = ctl_s2.row_top;
		rok[1] = 1'b1;
		rok[2] = ctl_s2.row_bot;
		cok[0] = ctl_s2.col_left;
		cok[1] = 1'b1;
		cok[2] = ctl_s2.col_right;
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					px[ch][r][c] = (rok[r] && cok[c]) ? win_q[r][c][CW*(2-ch) +: CW] : '0;
				end
			end
			gx[ch] = GW'(px[ch][0][2]) + (GW'(px[ch][1][2]) << 1) + GW'(px[ch][2][2])
				- GW'(px[ch][0][0]) - (GW'(px[ch][1][0]) << 1) - GW'(px[ch][2][0]);
			gy[ch] = GW'(px[ch][2][0]) + (GW'(px[ch][2][1]) << 1) + GW'(px[ch][2][2])
				- GW'(px[ch][0][0]) - (GW'(px[ch][0][1]) << 1) - GW'(px[ch][0][2]);
		end
	end

	// stage 3 gradients
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				gx_s3[ch] <= gx[ch];
				gy_s3[ch] <= gy[ch];
			end
		end
	end

	// squares of the gradients
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sq_x[ch] = gx_s3[ch] * gx_s3[ch];
			sq_y[ch] = gy_s3[ch] * gy_s3[ch];
		end
	end

	// stage 4 magnitude squared
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_s4[ch] <= sem_pkg::SUM_W'(sq_x[ch]) + sem_pkg::SUM_W'(sq_y[ch]);
			end
		end
	end

	// result tags for stages 3 and 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s3 <= {ctl_s2.emit, ctl_s2.last};
			tag_s4 <= tag_s3;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sem_root.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sem_root
// Rounded square root, one result bit per stage: finds the largest r with
// r*r - r below the input, which is the nearest integer root held at 255.
// ---------------------------------------------------------------------------
module sem_root (
	input  wire logic                       clk,
	input  wire logic                       adv,
	input  wire logic [sem_pkg::SUM_W-1:0]  sum,
	output logic      [sem_pkg::CH_W-1:0]   root
);

	localparam int RBW = sem_pkg::CH_W;
	localparam int BW  = sem_pkg::BASE_W;

	logic [sem_pkg::SUM_W-1:0] sum_s  [RBW-1];
	logic [BW-1:0]             base_s [RBW-1];
	logic [RBW-1:0]            root_s [RBW];

	for (genvar i = 0; i < RBW; i++) begin : g_step
		localparam int K = RBW - 1 - i;
		localparam logic [BW:0] BIAS = (BW+1)'((1 << (2 * K)) - (1 << K));

		logic [sem_pkg::SUM_W-1:0] src_sum;
		logic [BW-1:0]             src_base;
		logic [RBW-1:0]            src_root;
		logic [BW:0]               trial;
		logic                      take;

		if (i == 0) begin : g_first
			assign src_sum  = sum;
			assign src_base = '0;
			assign src_root = '0;
		end else begin : g_next
			assign src_sum  = sum_s[i-1];
			assign src_base = base_s[i-1];
			assign src_root = root_s[i-1];
		end

		// trial value of r*r - r with this bit set
		assign trial = (BW+1)'(src_base) + ((BW+1)'(src_root) << (K + 1)) + BIAS;
		assign take  = sem_pkg::SUM_W'(trial) < src_sum;

		always_ff @(posedge clk) begin
			if (adv) begin
				root_s[i] <= take ? (src_root | RBW'(1 << K)) : src_root;
			end
		end

		if (i < RBW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					sum_s[i]  <= src_sum;
					base_s[i] <= take ? BW'(trial) : src_base;
				end
			end
		end
	end

	assign root = root_s[RBW-1];

endmodule
`default_nettype wire
